FILE: design/sdq_pkg.sv
// Shared types and constants of the sleep deadline queue.
package sdq_pkg;

    localparam int TICK_W     = 63;
    localparam int ID_W       = 8;
    localparam int DUR_W      = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 72;
    localparam int ENTRY_W    = ID_W + TICK_W;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_SLEEP = 1'b1;

    typedef enum logic [1:0] {
        ST_QUEUED   = 2'd0,
        ST_RETURNED = 2'd1,
        ST_REJECTED = 2'd2,
        ST_WOKEN    = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    in_ready;
        logic    head_read;
        logic    pop;
        logic    walk_read;
        logic    walk_shift;
        logic    walk_place;
        logic    out_load;
        logic    out_from_pend;
        logic    out_last;
        status_t out_status;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic in_fire;
        logic in_kind;
        logic in_nonpos;
        logic full;
        logic empty;
        logic cnt_zero;
        logic due;
        logic later;
        logic out_free;
    } sts_t;

endpackage

FILE: design/sdq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sdq_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/sdq_datapath.sv
// Datapath: tick counter, ring-buffer queue storage, walk pointers and result register.
module sdq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sdq_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sdq_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast,
    input  sdq_pkg::cmd_t                    cmd,
    output sdq_pkg::sts_t                    sts
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

    logic [sdq_pkg::TICK_W-1:0]  tick_reg;
    logic [sdq_pkg::TICK_W-1:0]  target_reg;
    logic [sdq_pkg::ID_W-1:0]    id_reg;
    logic [sdq_pkg::ID_W-1:0]    pend_id_reg;
    logic [AW-1:0]               head_reg;
    logic [AW-1:0]               tail_reg;
    logic [AW-1:0]               walk_reg;
    logic [CW-1:0]               fill_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        m_tvalid_reg;
    logic [sdq_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]                  m_tuser_reg;
    logic                        m_tlast_reg;

    logic                        in_fire;
    logic [sdq_pkg::ID_W-1:0]    in_id;
    logic [sdq_pkg::DUR_W-1:0]   in_dur;
    logic [sdq_pkg::TICK_W:0]    sum;
    logic [sdq_pkg::TICK_W-1:0]  target_next;
    logic [AW-1:0]               walk_prev;
    logic [AW-1:0]               head_succ;
    logic [AW-1:0]               tail_succ;

    logic                        ram_wr_en;
    logic [AW-1:0]               ram_wr_addr;
    logic [sdq_pkg::ENTRY_W-1:0] ram_wr_data;
    logic                        ram_rd_en;
    logic [AW-1:0]               ram_rd_addr;
    logic [sdq_pkg::ENTRY_W-1:0] ram_rd_data;
    logic [sdq_pkg::TICK_W-1:0]  rd_target;
    logic [sdq_pkg::ID_W-1:0]    rd_id;
    logic [sdq_pkg::ID_W-1:0]    out_id;

    assign in_fire = s_tvalid & cmd.in_ready;
    assign in_id   = s_tdata[sdq_pkg::ID_W-1:0];
    assign in_dur  = s_tdata[sdq_pkg::ID_W +: sdq_pkg::DUR_W];

    // Target saturates at the top of the tick range.
    assign sum = {1'b0, tick_reg} + (sdq_pkg::TICK_W + 1)'(in_dur[sdq_pkg::DUR_W-2:0]);
    assign target_next = sum[sdq_pkg::TICK_W] ? {sdq_pkg::TICK_W{1'b1}}
                                              : sum[sdq_pkg::TICK_W-1:0];

    assign walk_prev = (walk_reg == '0) ? LAST_SLOT : walk_reg - 1'b1;
    assign head_succ = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign tail_succ = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;

    assign rd_target = ram_rd_data[sdq_pkg::TICK_W-1:0];
    assign rd_id     = ram_rd_data[sdq_pkg::ENTRY_W-1:sdq_pkg::TICK_W];

    assign ram_rd_en   = cmd.head_read | cmd.walk_read;
    assign ram_rd_addr = cmd.head_read ? head_reg : walk_prev;
    assign ram_wr_en   = cmd.walk_shift | cmd.walk_place;
    assign ram_wr_addr = walk_reg;
    assign ram_wr_data = cmd.walk_shift ? ram_rd_data : {id_reg, target_reg};

    sdq_ram #(
        .DATA_W (sdq_pkg::ENTRY_W),
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg     <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (in_fire && s_tuser == sdq_pkg::KIND_TICK) begin
                tick_reg <= tick_reg + 1'b1;
            end
            if (cmd.pop) begin
                head_reg <= head_succ;
                fill_reg <= fill_reg - 1'b1;
            end else if (cmd.walk_place) begin
                tail_reg <= tail_succ;
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign out_id = cmd.out_from_pend ? pend_id_reg : id_reg;

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            id_reg     <= in_id;
            target_reg <= target_next;
            walk_reg   <= tail_reg;
            cnt_reg    <= fill_reg;
        end else if (cmd.walk_shift) begin
            walk_reg <= walk_prev;
            cnt_reg  <= cnt_reg - 1'b1;
        end
        if (cmd.pop) begin
            pend_id_reg <= rd_id;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= sdq_pkg::M_TDATA_W'({tick_reg, out_id});
            m_tuser_reg <= cmd.out_status;
            m_tlast_reg <= cmd.out_last;
        end
    end

    assign s_tready = cmd.in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign sts.in_fire   = in_fire;
    assign sts.in_kind   = s_tuser;
    assign sts.in_nonpos = in_dur[sdq_pkg::DUR_W-1] | (in_dur == '0);
    assign sts.full      = (fill_reg == CW'(QUEUE_DEPTH));
    assign sts.empty     = (fill_reg == '0);
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.due       = (rd_target <= tick_reg);
    assign sts.later     = (rd_target > target_reg);
    assign sts.out_free  = ~m_tvalid_reg | m_tready;

endmodule

FILE: design/sdq_ctrl.sv
// Controller: sequences tick expiry walks, sorted insertion walks and result hand-off.
module sdq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  sdq_pkg::sts_t sts,
    output sdq_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        IDLE,
        T_RD,
        T_CMP,
        T_END,
        I_RD,
        I_CMP,
        RESP
    } state_t;

    state_t           state_reg, state_next;
    logic             pend_reg, pend_next;
    sdq_pkg::status_t resp_reg, resp_next;

    always_comb begin
        cmd            = '0;
        cmd.out_status = sdq_pkg::ST_WOKEN;
        state_next     = state_reg;
        pend_next      = pend_reg;
        resp_next      = resp_reg;
        case (state_reg)
            IDLE: begin
                cmd.in_ready = 1'b1;
                if (sts.in_fire) begin
                    if (sts.in_kind == sdq_pkg::KIND_TICK) begin
                        state_next = T_RD;
                    end else if (sts.in_nonpos) begin
                        resp_next  = sdq_pkg::ST_RETURNED;
                        state_next = RESP;
                    end else if (sts.full) begin
                        resp_next  = sdq_pkg::ST_REJECTED;
                        state_next = RESP;
                    end else begin
                        state_next = I_RD;
                    end
                end
            end
            T_RD: begin
                if (sts.empty) begin
                    state_next = T_END;
                end else begin
                    cmd.head_read = 1'b1;
                    state_next    = T_CMP;
                end
            end
            T_CMP: begin
                if (!sts.due) begin
                    state_next = T_END;
                end else if (!pend_reg || sts.out_free) begin
                    // The held sleeper is known not to be the final one.
                    cmd.out_load      = pend_reg;
                    cmd.out_from_pend = 1'b1;
                    cmd.pop           = 1'b1;
                    pend_next         = 1'b1;
                    state_next        = T_RD;
                end
            end
            T_END: begin
                if (!pend_reg) begin
                    state_next = IDLE;
                end else if (sts.out_free) begin
                    cmd.out_load      = 1'b1;
                    cmd.out_from_pend = 1'b1;
                    cmd.out_last      = 1'b1;
                    pend_next         = 1'b0;
                    state_next        = IDLE;
                end
            end
            I_RD: begin
                if (sts.cnt_zero) begin
                    cmd.walk_place = 1'b1;
                    resp_next      = sdq_pkg::ST_QUEUED;
                    state_next     = RESP;
                end else begin
                    cmd.walk_read = 1'b1;
                    state_next    = I_CMP;
                end
            end
            I_CMP: begin
                if (sts.later) begin
                    cmd.walk_shift = 1'b1;
                    state_next     = I_RD;
                end else begin
                    cmd.walk_place = 1'b1;
                    resp_next      = sdq_pkg::ST_QUEUED;
                    state_next     = RESP;
                end
            end
            RESP: begin
                cmd.out_status = resp_reg;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            pend_reg  <= 1'b0;
            resp_reg  <= sdq_pkg::ST_QUEUED;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            resp_reg  <= resp_next;
        end
    end

endmodule

FILE: design/sleep_deadline_queue_unit.sv
// Top level of the sorted timer deadline queue.
//
// This block keeps a 63-bit counter of tick items and a queue of up to
// QUEUE_DEPTH sleepers sorted by wake-up tick, held as a ring buffer in one RAM.
// A tick item advances the counter and then returns a woken result for each
// sleeper whose target is at or below the new count, earliest first, with
// m_tlast on the final one; a tick that wakes nobody gives no result. A sleep
// item gets exactly one result: queued, returned at once (duration zero or
// less) or rejected (queue full). Its target is the counter plus the duration,
// saturated at the top of the range, and it goes behind every entry with an
// equal or earlier target. Items are taken one at a time. A tick walks the
// queue from its head, reading each head entry and then comparing it, and
// stops at the first entry not yet due or when the queue is empty. A queued
// sleep walks from the tail with a sorted-insertion walk that moves one RAM
// entry per read-then-write pair, and ends at an entry with an equal or
// earlier target or at the head. A new result waits while the last one is held
// by a low m_tready.
module sleep_deadline_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0 up: sleeper_id[7:0], duration[39:8].
    input  logic [sdq_pkg::S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0 up: kind[0] (0 tick, 1 sleep request).
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0 up: woken_id[7:0], current_tick[70:8], zero pad[71].
    output logic [sdq_pkg::M_TDATA_W-1:0] m_tdata,
    // Fields from bit 0 up: status[1:0].
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);

    // Commands and status between the controller and the datapath.
    sdq_pkg::cmd_t cmd;
    sdq_pkg::sts_t sts;

    // The controller decides each step of a walk from the datapath's compares.
    sdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath owns the counter, the queue RAM and the result register.
    sdq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

FILE: design/sdq_checker.sv
// Port-level checks of the sleep deadline queue and their binding to the top level.
module sdq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sdq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                    m_tuser,
    input logic                          m_tlast
);

    // A result waiting on the consumer keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Items are processed one at a time, so an accept is never followed at once by another.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // Every result other than a wake-up is the only result of its item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != sdq_pkg::ST_WOKEN |-> m_tlast)
        else $error("single result without last");

    // Reset leaves no result on the output.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sleep_deadline_queue_unit sdq_checker u_sdq_checker (.*);

FILE: tb/sv/tb_top.sv
// Self-checking stream testbench for the sorted sleep deadline queue.
`timescale 1ns / 1ps

module tb_top;

    import sdq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_AT      = 120;   // items taken before the long receiver hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 120;   // covers a full wake-up walk with output stalls
    localparam int IDLE_LIMIT   = 4000;

    // One input item: kind travels on s_tuser, the rest on s_tdata.
    typedef struct packed {
        logic             kind;
        logic [ID_W-1:0]  id;
        logic [DUR_W-1:0] dur;
    } request_t;

    // One result as the block should present it.
    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] tick;
        logic              last;
    } reply_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = KIND_TICK;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    // Shadow copy of the block's state: tick counter and sorted sleeper list.
    logic [TICK_W-1:0] shadow_tick;
    logic [TICK_W-1:0] shadow_target [QUEUE_DEPTH];
    logic [ID_W-1:0]   shadow_id     [QUEUE_DEPTH];
    int                shadow_fill;

    request_t queued_requests[$];   // items still to be offered
    reply_t   pending_replies[$];   // results predicted but not yet seen
    request_t on_bus;
    reply_t   oldest_reply;

    int mismatches  = 0;
    int items_taken = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    int big_left    = 3;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int rx_mode     = 0;
    int mode_left   = 0;
    int rx_cycle    = 0;
    int idle_cycles = 0;

    sleep_deadline_queue_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Applies one accepted item to the shadow state and queues the results it causes.
    task automatic apply_to_shadow_queue(input request_t req);
        logic [TICK_W:0]   sum;
        logic [TICK_W-1:0] target;
        int                pos;
        int                n;
        reply_t            r;
        begin
            if (req.kind == KIND_SLEEP) begin
                r.id   = req.id;
                r.tick = shadow_tick;
                r.last = 1'b1;
                if (req.dur[DUR_W-1] || req.dur == '0) begin
                    r.status = ST_RETURNED;
                end else if (shadow_fill >= QUEUE_DEPTH) begin
                    r.status = ST_REJECTED;
                end else begin
                    // The target saturates at the top of the counter range.
                    sum    = {1'b0, shadow_tick} + {{(TICK_W + 1 - DUR_W){1'b0}}, req.dur};
                    target = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
                    // Equal targets keep their order of arrival.
                    pos = 0;
                    while (pos < shadow_fill && shadow_target[pos] <= target) pos++;
                    for (int i = shadow_fill; i > pos; i--) begin
                        shadow_target[i] = shadow_target[i-1];
                        shadow_id[i]     = shadow_id[i-1];
                    end
                    shadow_target[pos] = target;
                    shadow_id[pos]     = req.id;
                    shadow_fill++;
                    r.status = ST_QUEUED;
                end
                pending_replies.push_back(r);
            end else begin
                // The counter wraps at its width; everyone due is woken in order.
                shadow_tick = shadow_tick + 1'b1;
                n = 0;
                while (n < shadow_fill && shadow_target[n] <= shadow_tick) n++;
                for (int i = 0; i < n; i++) begin
                    r.status = ST_WOKEN;
                    r.id     = shadow_id[i];
                    r.tick   = shadow_tick;
                    r.last   = (i == n - 1);
                    pending_replies.push_back(r);
                end
                for (int i = n; i < shadow_fill; i++) begin
                    shadow_target[i-n] = shadow_target[i];
                    shadow_id[i-n]     = shadow_id[i];
                end
                shadow_fill = shadow_fill - n;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        begin
            if (want !== got) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                mismatches++;
            end
        end
    endtask

    task automatic add_sleep(input logic [ID_W-1:0] id, input logic [DUR_W-1:0] dur);
        request_t req;
        begin
            req.kind = KIND_SLEEP;
            req.id   = id;
            req.dur  = dur;
            queued_requests.push_back(req);
        end
    endtask

    // A tick carries random id and duration bits, which the block must ignore.
    task automatic add_tick();
        request_t req;
        begin
            req.kind = KIND_TICK;
            req.id   = ID_W'($urandom_range(0, 255));
            req.dur  = $urandom;
            queued_requests.push_back(req);
        end
    endtask

    // Mostly short sleeps so that sleepers are woken often; a few very long
    // ones stay queued for the rest of the run, so their number is capped.
    function automatic logic [DUR_W-1:0] random_duration();
        int pick;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10) return $urandom | 32'h8000_0000;
            if (pick < 13) return '0;
            if (pick < 15 && big_left > 0) begin
                big_left--;
                return $urandom >> 1;
            end
            return $urandom_range(1, 12);
        end
    endfunction

    // Driver: offers items in bursts with random gaps and predicts each
    // accepted item at the edge where it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_to_shadow_queue(on_bus);
                items_taken <= items_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (queued_requests.size() != 0) begin
                    on_bus = queued_requests.pop_front();
                    s_tdata  <= {on_bus.dur, on_bus.id};
                    s_tuser  <= on_bus.kind;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // Some bursts are followed by no gap at all, giving long
                        // stretches of back-to-back items.
                        burst_left = $urandom_range(0, 23);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: m_tready follows one of four patterns, chosen anew whenever mode_left runs out.
    // Once, early in the random part, it holds off for a long stretch so that
    // the block backs up and stalls its input while items are still offered.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (!hold_done && items_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_tready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_tready <= rx_cycle[2];
                    end
                endcase
            end
        end
    end

    // Monitor: every accepted result is matched against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: result expected none actual status %0d id %0h tick %0d last %b",
                         $time, m_tuser, m_tdata[7:0], m_tdata[70:8], m_tlast);
                mismatches++;
            end else begin
                oldest_reply = pending_replies.pop_front();
                check_field("status", 64'(oldest_reply.status), 64'(m_tuser));
                check_field("woken_id", 64'(oldest_reply.id), 64'(m_tdata[7:0]));
                check_field("current_tick", 64'(oldest_reply.tick), 64'(m_tdata[70:8]));
                check_field("last", 64'(oldest_reply.last), 64'(m_tlast));
            end
        end
    end

    // Watchdog: counts cycles without any handshake while work is outstanding.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (queued_requests.size() == 0 && !s_tvalid && pending_replies.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int n_random;
        int run_len;
        int ticks;

        shadow_tick = '0;
        shadow_fill = 0;

        // Directed part. A tick with nobody due gives no result at all.
        add_tick();
        // Zero, minus one and the most negative duration return at once.
        add_sleep(8'h00, 32'h0000_0000);
        add_sleep(8'hFF, 32'hFFFF_FFFF);
        add_sleep(8'h55, 32'h8000_0000);
        // The longest duration is queued and stays for the whole run.
        add_sleep(8'hAA, 32'h7FFF_FFFF);
        // Equal targets keep their order, an earlier target goes in front.
        add_sleep(8'h02, 32'd2);
        add_sleep(8'h03, 32'd2);
        add_sleep(8'h04, 32'd1);
        add_tick();
        add_tick();
        // Fill the queue to the top; the last request is rejected, and one
        // tick then wakes fifteen sleepers in a single walk.
        for (int k = 0; k < QUEUE_DEPTH; k++) add_sleep(ID_W'(8'h10 + k), 32'd1);
        add_tick();

        // Random part: mostly runs of sleeps followed by ticks, so that the
        // queue fills and drains, mixed with stretches of arbitrary items.
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) != 0) begin
                run_len = $urandom_range(1, QUEUE_DEPTH);
                ticks   = $urandom_range(1, 10);
                for (int k = 0; k < run_len; k++)
                    add_sleep(ID_W'($urandom_range(0, 255)), random_duration());
                for (int k = 0; k < ticks; k++) add_tick();
                n_random += run_len + ticks;
            end else begin
                for (int k = 0; k < 20; k++) begin
                    if ($urandom_range(0, 9) < 4) add_tick();
                    else add_sleep(ID_W'($urandom_range(0, 255)), random_duration());
                end
                n_random += 20;
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (queued_requests.size() != 0 || s_tvalid) @(posedge aclk);
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/sdq_pkg.sv
design/sdq_ram.sv
design/sdq_datapath.sv
design/sdq_ctrl.sv
design/sleep_deadline_queue_unit.sv
design/sdq_checker.sv
tb/sv/tb_top.sv
